[sv/dlcc_pkg.sv]
// Shared constants for the circle-clipped DDA line rasterizer.
`default_nettype none

package dlcc_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COLOR_BITS     = 24;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS   = 2'd2;

endpackage

`default_nettype wire

[sv/dlcc_front.sv]
// Front end: classifies a request and orders the line endpoints by major axis.
`default_nettype none

module dlcc_front #(
   parameter int COORD_BITS = dlcc_pkg::COORD_BITS_DEF,
   parameter int ENTRY_BITS = 6 * dlcc_pkg::COORD_BITS_DEF + 29
) (
   input  wire logic                               cmd,
   input  wire logic signed [COORD_BITS-1:0]       x_start,
   input  wire logic signed [COORD_BITS-1:0]       y_start,
   input  wire logic signed [COORD_BITS-1:0]       x_end,
   input  wire logic signed [COORD_BITS-1:0]       y_end,
   input  wire logic [dlcc_pkg::COLOR_BITS-1:0]    color,
   output logic [ENTRY_BITS-1:0]                   entry
);
   import dlcc_pkg::*;

   localparam int C = COORD_BITS;

   logic signed [C:0]   dx, dy, num;
   logic [C:0]          adx, ady, num_mag, den;
   logic                major_is_x, swap, num_neg;
   logic signed [C-1:0] a0, a1, b0, b1, ma0, ma1, mi0, mi1;

   always_comb begin
      dx         = {x_end[C-1], x_end} - {x_start[C-1], x_start};
      dy         = {y_end[C-1], y_end} - {y_start[C-1], y_start};
      adx        = dx[C] ? -dx : dx;
      ady        = dy[C] ? -dy : dy;
      major_is_x = (adx >= ady);
      a0         = major_is_x ? x_start : y_start;
      a1         = major_is_x ? x_end   : y_end;
      b0         = major_is_x ? y_start : x_start;
      b1         = major_is_x ? y_end   : x_end;
      swap       = (a0 > a1);
      ma0        = swap ? a1 : a0;
      ma1        = swap ? a0 : a1;
      mi0        = swap ? b1 : b0;
      mi1        = swap ? b0 : b1;
      den        = {ma1[C-1], ma1} - {ma0[C-1], ma0};
      num        = {mi1[C-1], mi1} - {mi0[C-1], mi0};
      num_neg    = num[C];
      num_mag    = num_neg ? -num : num;
   end

   assign entry = {cmd, major_is_x, num_neg, ma0, ma1, mi0, mi1, num_mag, den, color};

endmodule

`default_nettype wire

[sv/dlcc_queue.sv]
// Short request queue between the front end and the pixel sequencer.
`default_nettype none

module dlcc_queue #(
   parameter int WIDTH = 6 * dlcc_pkg::COORD_BITS_DEF + 29
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rdata
);
   import dlcc_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[sv/dlcc_back.sv]
// Back end: slope divider, DDA stepping, circle test and result register.
`default_nettype none

module dlcc_back #(
   parameter int COORD_BITS = dlcc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlcc_pkg::FRAC_BITS_DEF,
   parameter int ENTRY_BITS = 6 * dlcc_pkg::COORD_BITS_DEF + 29
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  q_empty,
   output logic                                       q_pop,
   input  wire logic [ENTRY_BITS-1:0]                 q_entry,
   input  wire logic                                  csr_we,
   input  wire logic [dlcc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [COORD_BITS-1:0]                 csr_wdata,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic [COORD_BITS-1:0]                      rsp_pixel_x,
   output logic [COORD_BITS-1:0]                      rsp_pixel_y,
   output logic [dlcc_pkg::COLOR_BITS-1:0]            rsp_color_out,
   output logic                                       rsp_visible,
   output logic                                       rsp_last,
   output logic                                       rsp_valid_res
);
   import dlcc_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int MW   = C + 2;
   localparam int AW   = C + F + 1;
   localparam int SW   = F + 2;
   localparam int DW   = C + 2;
   localparam int NW   = C + F + 3;
   localparam int QW   = F + 1;
   localparam int CW   = $clog2(QW + 1);
   localparam int EXW  = MW + 1;
   localparam int SQW  = 2 * EXW;
   localparam int SUMW = SQW + 1;
   localparam int R2W  = 2 * C;
   localparam int CB   = COLOR_BITS;

   localparam logic [AW:0] RND_HALF = {{(AW + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
   localparam logic [AW:0] RND_LOW  = {{(AW + 2 - F){1'b0}}, {(F - 1){1'b1}}};

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EP0  = 7'b0000010,
      S_EP1  = 7'b0000100,
      S_EPC  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_PIX  = 7'b0100000,
      S_EMIT = 7'b1000000
   } back_state_type;

   logic                 e_cmd, e_mx, e_neg;
   logic signed [C-1:0]  e_ma0, e_ma1, e_mi0, e_mi1;
   logic [C:0]           e_mag, e_den;
   logic [CB-1:0]        e_color;

   assign {e_cmd, e_mx, e_neg, e_ma0, e_ma1, e_mi0, e_mi1, e_mag, e_den, e_color} = q_entry;

   back_state_type       state_ff, state_in;
   logic                 line_active_ff, line_active_in;
   logic                 major_is_x_ff, major_is_x_in;
   logic                 both_inside_ff, both_inside_in;
   logic signed [C-1:0]  major_pos_ff, major_pos_in;
   logic signed [C-1:0]  major_end_ff, major_end_in;
   logic signed [AW-1:0] minor_accum_ff, minor_accum_in;
   logic signed [SW-1:0] slope_ff, slope_in;
   logic [CB-1:0]        line_color_ff, line_color_in;
   logic signed [C-1:0]  mi1_ff, mi1_in;
   logic                 num_neg_ff, num_neg_in;
   logic [C:0]           num_mag_ff, num_mag_in;
   logic [C:0]           den_ff, den_in;
   logic                 ins0_ff, ins0_in;
   logic                 null_ff, null_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [QW-1:0]        nlo_ff, nlo_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [SQW-1:0]       sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic signed [C-1:0]  center_x_ff, center_x_in, center_y_ff, center_y_in;
   logic [R2W-1:0]       radius_sq_ff, radius_sq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]         rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [CB-1:0]        rsp_color_ff, rsp_color_in;
   logic                 rsp_visible_ff, rsp_visible_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_vres_ff, rsp_vres_in;

   logic [AW:0]           rsum;
   logic signed [MW-1:0]  minor_full, major_ext, pix_x, pix_y, sel_x, sel_y;
   logic signed [MW-1:0]  end_major, end_minor;
   logic signed [EXW-1:0] ex, ey;
   logic signed [SQW-1:0] prod_x, prod_y;
   logic [SUMW-1:0]       dist_sq;
   logic                  in_circle, fin, out_free;
   logic [NW-1:0]         n_full;
   logic [DW:0]           rem2, div_d, rem_diff;
   logic                  ge;
   logic [QW-1:0]         quo_next;
   logic [SW-1:0]         q_ext;

   always_comb begin
      rsum       = {minor_accum_ff[AW-1], minor_accum_ff}
                 + (minor_accum_ff[AW-1] ? RND_LOW : RND_HALF);
      minor_full = rsum[AW:F];
      major_ext  = {{2{major_pos_ff[C-1]}}, major_pos_ff};
      pix_x      = major_is_x_ff ? major_ext : minor_full;
      pix_y      = major_is_x_ff ? minor_full : major_ext;
      end_major  = {{2{major_end_ff[C-1]}}, major_end_ff};
      end_minor  = {{2{mi1_ff[C-1]}}, mi1_ff};
      if (state_ff == S_EP1) begin
         sel_x = major_is_x_ff ? end_major : end_minor;
         sel_y = major_is_x_ff ? end_minor : end_major;
      end else begin
         sel_x = pix_x;
         sel_y = pix_y;
      end
      ex        = {sel_x[MW-1], sel_x} - {{(EXW - C){center_x_ff[C-1]}}, center_x_ff};
      ey        = {sel_y[MW-1], sel_y} - {{(EXW - C){center_y_ff[C-1]}}, center_y_ff};
      prod_x    = SQW'(ex) * SQW'(ex);
      prod_y    = SQW'(ey) * SQW'(ey);
      dist_sq   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      in_circle = dist_sq < {{(SUMW - R2W){1'b0}}, radius_sq_ff};
      fin       = (major_pos_ff >= major_end_ff);
      out_free  = ~rsp_valid_ff | rsp_pop;
      n_full    = {1'b0, num_mag_ff, {(F + 1){1'b0}}} + {{(NW - C - 1){1'b0}}, den_ff};
      rem2      = {rem_ff, nlo_ff[QW-1]};
      div_d     = {1'b0, den_ff, 1'b0};
      ge        = (rem2 >= div_d);
      rem_diff  = rem2 - div_d;
      quo_next  = {quo_ff[QW-2:0], ge};
      q_ext     = {1'b0, quo_next};
   end

   always_comb begin
      state_in       = state_ff;
      line_active_in = line_active_ff;
      major_is_x_in  = major_is_x_ff;
      both_inside_in = both_inside_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_accum_in = minor_accum_ff;
      slope_in       = slope_ff;
      line_color_in  = line_color_ff;
      mi1_in         = mi1_ff;
      num_neg_in     = num_neg_ff;
      num_mag_in     = num_mag_ff;
      den_in         = den_ff;
      ins0_in        = ins0_ff;
      null_in        = null_ff;
      rem_in         = rem_ff;
      nlo_in         = nlo_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      sqx_in         = prod_x;
      sqy_in         = prod_y;
      center_x_in    = center_x_ff;
      center_y_in    = center_y_ff;
      radius_sq_in   = radius_sq_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_pop;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_visible_in = rsp_visible_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_vres_in    = rsp_vres_ff;
      q_pop          = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X: center_x_in  = csr_wdata;
            CSR_CENTER_Y: center_y_in  = csr_wdata;
            CSR_RADIUS:   radius_sq_in = {{C{1'b0}}, csr_wdata} * {{C{1'b0}}, csr_wdata};
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (e_cmd == CMD_START) begin
                  major_is_x_in  = e_mx;
                  major_pos_in   = e_ma0;
                  major_end_in   = e_ma1;
                  minor_accum_in = {e_mi0[C-1], e_mi0, {F{1'b0}}};
                  line_color_in  = e_color;
                  mi1_in         = e_mi1;
                  num_neg_in     = e_neg;
                  num_mag_in     = e_mag;
                  den_in         = e_den;
                  null_in        = 1'b0;
                  state_in       = S_EP0;
               end else if (line_active_ff) begin
                  major_pos_in   = major_pos_ff + {{(C - 1){1'b0}}, 1'b1};
                  minor_accum_in = minor_accum_ff + {{(AW - SW){slope_ff[SW-1]}}, slope_ff};
                  null_in        = 1'b0;
                  state_in       = S_PIX;
               end else begin
                  null_in  = 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         S_EP0: begin
            state_in = S_EP1;
         end
         S_EP1: begin
            ins0_in  = in_circle;
            state_in = S_EPC;
         end
         S_EPC: begin
            both_inside_in = ins0_ff & in_circle;
            rem_in         = n_full[NW-1:F+1];
            nlo_in         = n_full[F:0];
            quo_in         = '0;
            cnt_in         = '0;
            if (den_ff == '0) begin
               slope_in = '0;
               state_in = S_PIX;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = ge ? rem_diff[DW-1:0] : rem2[DW-1:0];
            nlo_in = {nlo_ff[QW-2:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(QW - 1)) begin
               slope_in = num_neg_ff ? -q_ext : q_ext;
               state_in = S_PIX;
            end
         end
         S_PIX: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (null_ff) begin
                  rsp_x_in       = '0;
                  rsp_y_in       = '0;
                  rsp_color_in   = '0;
                  rsp_visible_in = 1'b0;
                  rsp_last_in    = 1'b0;
                  rsp_vres_in    = 1'b0;
               end else begin
                  rsp_x_in       = pix_x[C-1:0];
                  rsp_y_in       = pix_y[C-1:0];
                  rsp_color_in   = line_color_ff;
                  rsp_visible_in = both_inside_ff | in_circle;
                  rsp_last_in    = fin;
                  rsp_vres_in    = 1'b1;
                  line_active_in = ~fin;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         radius_sq_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         cnt_ff         <= cnt_in;
         center_x_ff    <= center_x_in;
         center_y_ff    <= center_y_in;
         radius_sq_ff   <= radius_sq_in;
      end
   end

   always_ff @(posedge clock) begin
      major_is_x_ff  <= major_is_x_in;
      both_inside_ff <= both_inside_in;
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      minor_accum_ff <= minor_accum_in;
      slope_ff       <= slope_in;
      line_color_ff  <= line_color_in;
      mi1_ff         <= mi1_in;
      num_neg_ff     <= num_neg_in;
      num_mag_ff     <= num_mag_in;
      den_ff         <= den_in;
      ins0_ff        <= ins0_in;
      null_ff        <= null_in;
      rem_ff         <= rem_in;
      nlo_ff         <= nlo_in;
      quo_ff         <= quo_in;
      sqx_ff         <= sqx_in;
      sqy_ff         <= sqy_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_vres_ff    <= rsp_vres_in;
   end

   assign rsp_empty     = ~rsp_valid_ff;
   assign rsp_pixel_x   = rsp_x_ff;
   assign rsp_pixel_y   = rsp_y_ff;
   assign rsp_color_out = rsp_color_ff;
   assign rsp_visible   = rsp_visible_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_valid_res = rsp_vres_ff;

endmodule

`default_nettype wire

[sv/dda_line_circle_clipper.sv]
// Top level of the DDA line rasterizer with circular clipping window.
// Step request: queue head to result register via pop, square and compare (no square if no line is active).
// Start request: endpoint circle tests, then the one-bit-per-cycle slope divider (skipped if zero-length).
// The back-end sequencer takes a new request only after the last result is written to a free result register.
// Reset (synchronous): empties the request queue and result register, ends any line, clears center and radius.
`default_nettype none

module dda_line_circle_clipper #(
   parameter int COORD_BITS = dlcc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlcc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic                                 req_cmd,
   input  wire logic signed [COORD_BITS-1:0]         req_x_start,
   input  wire logic signed [COORD_BITS-1:0]         req_y_start,
   input  wire logic signed [COORD_BITS-1:0]         req_x_end,
   input  wire logic signed [COORD_BITS-1:0]         req_y_end,
   input  wire logic [dlcc_pkg::COLOR_BITS-1:0]      req_color_in,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic signed [COORD_BITS-1:0]              rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]              rsp_pixel_y,
   output logic [dlcc_pkg::COLOR_BITS-1:0]           rsp_color_out,
   output logic                                      rsp_visible,
   output logic                                      rsp_last,
   output logic                                      rsp_valid_res,
   input  wire logic                                 csr_we,
   input  wire logic [dlcc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0]                csr_wdata
);
   import dlcc_pkg::*;

   localparam int EW = 6 * COORD_BITS + 5 + COLOR_BITS;

   logic [EW-1:0] front_entry, q_entry;
   logic          q_empty, q_pop;

   dlcc_front #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_BITS (EW)
   ) u_front (
      .cmd     (req_cmd),
      .x_start (req_x_start),
      .y_start (req_y_start),
      .x_end   (req_x_end),
      .y_end   (req_y_end),
      .color   (req_color_in),
      .entry   (front_entry)
   );

   dlcc_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .wdata (front_entry),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_entry)
   );

   dlcc_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .ENTRY_BITS (EW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_entry       (q_entry),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_color_out (rsp_color_out),
      .rsp_visible   (rsp_visible),
      .rsp_last      (rsp_last),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for the circle-clipped DDA line rasterizer: directed and random lines, scoreboarded.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dlcc_pkg::*;

   localparam int CW          = COORD_BITS_DEF;
   localparam int FB          = FRAC_BITS_DEF;
   localparam longint CMIN    = -(longint'(1) << (CW - 1));
   localparam longint CMAX    = (longint'(1) << (CW - 1)) - 1;
   localparam int SETTLE_WAIT = FB + 12;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 160;

   typedef struct {
      logic                 cmd;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic signed [CW-1:0] xe;
      logic signed [CW-1:0] ye;
      logic [COLOR_BITS-1:0] color;
   } req_type;

   typedef struct {
      logic [CW-1:0]         x;
      logic [CW-1:0]         y;
      logic [COLOR_BITS-1:0] color;
      logic                  vis;
      logic                  fin;
      logic                  ok;
   } pixel_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_push = 1'b0;
   logic                         req_full;
   logic                         req_cmd = 1'b0;
   logic signed [CW-1:0]         req_x_start = '0;
   logic signed [CW-1:0]         req_y_start = '0;
   logic signed [CW-1:0]         req_x_end = '0;
   logic signed [CW-1:0]         req_y_end = '0;
   logic [COLOR_BITS-1:0]        req_color_in = '0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic signed [CW-1:0]         rsp_pixel_x;
   logic signed [CW-1:0]         rsp_pixel_y;
   logic [COLOR_BITS-1:0]        rsp_color_out;
   logic                         rsp_visible;
   logic                         rsp_last;
   logic                         rsp_valid_res;
   logic                         csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [CW-1:0]                csr_wdata = '0;

   // clipping window and line tracer state of the predictor
   longint clip_cx = 0, clip_cy = 0, clip_r = 0;
   logic   tracing = 1'b0, x_major = 1'b0, ends_inside = 1'b0;
   longint maj_at = 0, maj_stop = 0, minor_fx = 0, step_fx = 0;
   logic [COLOR_BITS-1:0] ink = '0;

   pixel_type pixel_q[$];
   int     mismatches = 0;
   int     issued = 0;
   int     cycles = 0;
   bit     idle_on = 1'b1;

   dda_line_circle_clipper dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_cmd(req_cmd),
      .req_x_start(req_x_start), .req_y_start(req_y_start),
      .req_x_end(req_x_end), .req_y_end(req_y_end), .req_color_in(req_color_in),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_pixel_x(rsp_pixel_x), .rsp_pixel_y(rsp_pixel_y),
      .rsp_color_out(rsp_color_out), .rsp_visible(rsp_visible),
      .rsp_last(rsp_last), .rsp_valid_res(rsp_valid_res),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint rnd(longint lo, longint hi);
      return lo + longint'($urandom_range(int'(hi - lo)));
   endfunction

   function automatic logic signed [CW-1:0] clamp(longint v);
      if (v < CMIN) return CMIN[CW-1:0];
      if (v > CMAX) return CMAX[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic logic in_circle(longint px, longint py);
      longint ex, ey;
      ex = px - clip_cx;
      ey = py - clip_cy;
      return (ex * ex + ey * ey) < clip_r * clip_r;
   endfunction

   function automatic longint round_minor(longint a);
      longint half;
      half = longint'(1) << (FB - 1);
      if (a >= 0) return (a + half) >>> FB;
      return -((-a + half) >>> FB);
   endfunction

   function automatic pixel_type predict_pixel(req_type r);
      pixel_type p;
      longint x1, y1, x2, y2, ma0, ma1, mi0, mi1, num, den, q, t, minor, px, py;
      p = '{default: '0};
      if (r.cmd == CMD_START) begin
         x1 = r.xs;
         y1 = r.ys;
         x2 = r.xe;
         y2 = r.ye;
         x_major = mag(x2 - x1) >= mag(y2 - y1);
         ma0 = x_major ? x1 : y1;
         ma1 = x_major ? x2 : y2;
         mi0 = x_major ? y1 : x1;
         mi1 = x_major ? y2 : x2;
         if (ma0 > ma1) begin
            t = ma0; ma0 = ma1; ma1 = t;
            t = mi0; mi0 = mi1; mi1 = t;
         end
         ends_inside = in_circle(x1, y1) && in_circle(x2, y2);
         ink = r.color;
         num = mi1 - mi0;
         den = ma1 - ma0;
         q = 0;
         if (den > 0) begin
            t = mag(num) * (longint'(1) << FB);
            q = (2 * t + den) / (2 * den);
            if (num < 0) q = -q;
         end
         step_fx = q;
         maj_at = ma0;
         maj_stop = ma1;
         minor_fx = mi0 * (longint'(1) << FB);
      end else if (!tracing) begin
         return p;
      end else begin
         maj_at = maj_at + 1;
         minor_fx = minor_fx + step_fx;
      end
      minor = round_minor(minor_fx);
      px = x_major ? maj_at : minor;
      py = x_major ? minor : maj_at;
      p.x = px[CW-1:0];
      p.y = py[CW-1:0];
      p.color = ink;
      p.vis = ends_inside || in_circle(px, py);
      p.fin = maj_at >= maj_stop;
      p.ok = 1'b1;
      tracing = !p.fin;
      return p;
   endfunction

   task automatic compare(string what, logic [COLOR_BITS-1:0] want, logic [COLOR_BITS-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pixel_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected pixel x %0h y %0h", $time, rsp_pixel_x, rsp_pixel_y);
            end else begin
               want = pixel_q.pop_front();
               compare("pixel_x", COLOR_BITS'(want.x), COLOR_BITS'($unsigned(rsp_pixel_x)));
               compare("pixel_y", COLOR_BITS'(want.y), COLOR_BITS'($unsigned(rsp_pixel_y)));
               compare("color_out", want.color, rsp_color_out);
               compare("visible", COLOR_BITS'(want.vis), COLOR_BITS'(rsp_visible));
               compare("last", COLOR_BITS'(want.fin), COLOR_BITS'(rsp_last));
               compare("valid_res", COLOR_BITS'(want.ok), COLOR_BITS'(rsp_valid_res));
            end
         end
         rsp_pop <= !idle_on || ($urandom_range(99) >= 16);
      end
   end

   task automatic send_req(req_type r);
      if (idle_on && $urandom_range(99) < 16) begin
         req_push <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_cmd <= r.cmd;
      req_x_start <= r.xs;
      req_y_start <= r.ys;
      req_x_end <= r.xe;
      req_y_end <= r.ye;
      req_color_in <= r.color;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      pixel_q.push_back(predict_pixel(r));
      issued++;
   endtask

   task automatic start_line(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                             logic signed [CW-1:0] x2, logic signed [CW-1:0] y2,
                             logic [COLOR_BITS-1:0] color);
      req_type r;
      r = '{cmd: CMD_START, xs: x1, ys: y1, xe: x2, ye: y2, color: color};
      send_req(r);
   endtask

   task automatic step_line();
      req_type r;
      r = '{cmd: CMD_STEP, xs: CW'($urandom), ys: CW'($urandom), xe: CW'($urandom),
            ye: CW'($urandom), color: COLOR_BITS'($urandom)};
      send_req(r);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_window(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                             logic [CW-1:0] r);
      settle();
      csr_we <= 1'b1;
      csr_index <= CSR_CENTER_X;
      csr_wdata <= cx;
      @(posedge clock);
      csr_index <= CSR_CENTER_Y;
      csr_wdata <= cy;
      @(posedge clock);
      csr_index <= CSR_RADIUS;
      csr_wdata <= r;
      @(posedge clock);
      csr_we <= 1'b0;
      clip_cx = cx;
      clip_cy = cy;
      clip_r = r;
   endtask

   task automatic test_idle_state();
      step_line();
      start_line(5, -7, 5, -7, 24'h123456);
      step_line();
   endtask

   task automatic test_directed_lines();
      set_window(0, 0, 100);
      start_line(4, 1, 1, 1, 24'h00ff00);
      repeat (4) step_line();
      start_line(10, -20, 7, -12, 24'h0000ff);
      repeat (2) step_line();
      start_line(0, 0, -5, 5, 24'hff0000);
      repeat (2) step_line();
      start_line(0, 0, 2, 1, 24'h800001);
      repeat (2) step_line();
      start_line(0, 0, 2, -1, 24'h7ffffe);
      repeat (2) step_line();
      start_line(10, 10, 20, -30, 24'h555555);
      step_line();
      start_line(98, 0, 102, 1, 24'haaaaaa);
      repeat (4) step_line();
   endtask

   task automatic test_extremes();
      set_window(CMIN[CW-1:0], CMAX[CW-1:0], {CW{1'b1}});
      start_line(CMIN[CW-1:0], CMAX[CW-1:0], CMAX[CW-1:0], CMIN[CW-1:0], 24'hffffff);
      repeat (2) step_line();
      start_line(CMAX[CW-1:0], CMIN[CW-1:0], CMIN[CW-1:0], CMAX[CW-1:0], 24'h000000);
      step_line();
      set_window(CMAX[CW-1:0], CMIN[CW-1:0], 0);
      start_line(CMAX[CW-1:0], CMAX[CW-1:0], CMIN[CW-1:0], CMIN[CW-1:0], 24'h0f0f0f);
      step_line();
   endtask

   task automatic random_line();
      longint x1, y1, x2, y2, span, n, pick, reach;
      pick = $urandom_range(99);
      if (pick < 8) begin
         step_line();
         return;
      end
      reach = clip_r + 16;
      if ($urandom_range(1) == 1) begin
         x1 = clip_cx + rnd(-reach, reach);
         y1 = clip_cy + rnd(-reach, reach);
      end else begin
         x1 = rnd(CMIN, CMAX);
         y1 = rnd(CMIN, CMAX);
      end
      x1 = clamp(x1);
      y1 = clamp(y1);
      if (pick < 80) span = 12;
      else if (pick < 95) span = 150;
      else span = CMAX - CMIN;
      x2 = clamp(x1 + rnd(-span, span));
      y2 = clamp(y1 + rnd(-span, span));
      start_line(x1[CW-1:0], y1[CW-1:0], x2[CW-1:0], y2[CW-1:0], COLOR_BITS'($urandom));
      n = (mag(x2 - x1) >= mag(y2 - y1)) ? mag(x2 - x1) : mag(y2 - y1);
      if (n > 150) begin
         n = rnd(0, 40);
      end else begin
         pick = $urandom_range(99);
         if (pick >= 85) n = n + rnd(1, 2);
         else if (pick >= 70) n = rnd(0, n);
      end
      repeat (n) step_line();
   endtask

   task automatic test_random_lines();
      int goal;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_window(CW'($urandom), CW'($urandom), 0);
            5: set_window(CW'($urandom), CW'($urandom), {CW{1'b1}});
            default: set_window(CW'($urandom), CW'($urandom),
                                CW'($urandom_range((ph % 2 == 1) ? 600 : 4095)));
         endcase
         idle_on = (ph != 3);
         goal = issued + PHASE_ITEMS;
         while (issued < goal) random_line();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_idle_state();
      test_directed_lines();
      test_extremes();
      test_random_lines();
      settle();
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
